/* hdl/irpd_pkg.sv */
// Shared types, constants and window arithmetic for the IR pulse-distance decoder.
package irpd_pkg;

  localparam int TICK_US_DEF   = 50;
  localparam int CODE_BITS_DEF = 32;

  // Nominal durations in microseconds.
  localparam int TW = 13;
  localparam logic [TW-1:0] HDR_MARK_US   = 13'd6700;
  localparam logic [TW-1:0] BIT_MARK_US   = 13'd845;
  localparam logic [TW-1:0] ZERO_SPACE_US = 13'd838;
  localparam logic [TW-1:0] ONE_SPACE_US  = 13'd3360;

  localparam logic [5:0] TOL_RESET    = 6'd25;
  localparam logic [7:0] EXCESS_RESET = 8'd100;

  // Configuration register indexes.
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_EXCESS    = 1'b1;

  // Width of a scaled window bound, target times (100 +/- tolerance).
  localparam int XW = 21;

  typedef struct packed {
    logic [XW-1:0] lo_x;
    logic [XW-1:0] hi_x;
  } win_t;

  typedef struct packed {
    win_t hdr;
    win_t bmark;
    win_t one;
    win_t zero;
  } win_set_t;

  typedef struct packed {
    logic first;
    logic last;
    logic dur_zero;
  } item_flags_t;

  // Bounds are scaled by 100 (tolerance in percent), so the datapath compares them
  // against the duration times 100*TICK_US instead of dividing.
  function automatic win_t win_calc(input logic [TW-1:0] desired, input logic [7:0] excess,
                                    input logic [5:0] tol, input logic is_mark);
    logic [TW-1:0] target;
    logic [7:0]    lo_f;
    logic [7:0]    hi_f;
    win_t          w;
    target = is_mark ? (desired + TW'(excess)) : (desired - TW'(excess));
    lo_f   = 8'd100 - 8'(tol);
    hi_f   = 8'd100 + 8'(tol);
    w.lo_x = XW'(target) * XW'(lo_f);
    w.hi_x = XW'(target) * XW'(hi_f);
    return w;
  endfunction

  function automatic win_set_t win_set_calc(input logic [7:0] excess, input logic [5:0] tol);
    win_set_t s;
    s.hdr   = win_calc(HDR_MARK_US, excess, tol, 1'b1);
    s.bmark = win_calc(BIT_MARK_US, excess, tol, 1'b1);
    s.one   = win_calc(ONE_SPACE_US, excess, tol, 1'b0);
    s.zero  = win_calc(ZERO_SPACE_US, excess, tol, 1'b0);
    return s;
  endfunction

endpackage

/* hdl/irpd_cfg.sv */
// Configuration registers and the scaled match windows derived from them.
module irpd_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [7:0]          cfg_wdata,
  output irpd_pkg::win_set_t  win
);

  logic [5:0]         tol_r, tol_nxt;
  logic [7:0]         exc_r, exc_nxt;
  irpd_pkg::win_set_t win_r, win_nxt;

  always_comb begin
    tol_nxt = tol_r;
    exc_nxt = exc_r;
    if (cfg_we) begin
      case (cfg_addr)
        irpd_pkg::REG_TOLERANCE: tol_nxt = cfg_wdata[5:0];
        irpd_pkg::REG_EXCESS:    exc_nxt = cfg_wdata;
        default: ;
      endcase
    end
    // Windows are refreshed in the same edge as the register write.
    win_nxt = irpd_pkg::win_set_calc(exc_nxt, tol_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= irpd_pkg::TOL_RESET;
      exc_r <= irpd_pkg::EXCESS_RESET;
      win_r <= irpd_pkg::win_set_calc(irpd_pkg::EXCESS_RESET, irpd_pkg::TOL_RESET);
    end else begin
      tol_r <= tol_nxt;
      exc_r <= exc_nxt;
      win_r <= win_nxt;
    end
  end

  assign win = win_r;

endmodule

/* hdl/irpd_front.sv */
// Front end: flags an incoming duration and forms its scaled products.
module irpd_front #(
  parameter int TICK_US = irpd_pkg::TICK_US_DEF,
  parameter int PW      = 17 + $clog2(100 * TICK_US + 1)
) (
  input  logic [15:0]          dur,
  input  logic                 first,
  input  logic                 last,
  output logic [PW-1:0]        p_inc,
  output logic [PW-1:0]        p_dec,
  output irpd_pkg::item_flags_t flags
);

  localparam int Div = 100 * TICK_US;

  // d >= floor(X/Div) holds exactly when (d+1)*Div > X, and
  // d <= floor(X/Div)+1 holds exactly when d is zero or (d-1)*Div <= X.
  assign p_inc = (PW'(dur) + PW'(1)) * PW'(Div);
  assign p_dec = (PW'(dur) - PW'(1)) * PW'(Div);

  assign flags.first    = first;
  assign flags.last     = last;
  assign flags.dur_zero = (dur == 16'd0);

endmodule

/* hdl/irpd_queue.sv */
// Two-entry queue between the front end and the decoding back end.
module irpd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         rvalid,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign full   = cnt_r[1];
  assign rvalid = (cnt_r != 2'd0);
  assign rdata  = mem_r[rptr_r];

endmodule

/* hdl/irpd_back.sv */
// Back end: capture sequencer, bit shifter and the result register.
module irpd_back #(
  parameter int TICK_US   = irpd_pkg::TICK_US_DEF,
  parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF,
  parameter int PW        = 17 + $clog2(100 * TICK_US + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  irpd_pkg::win_set_t    win,
  input  logic                  q_valid,
  input  logic [PW-1:0]         p_inc,
  input  logic [PW-1:0]         p_dec,
  input  irpd_pkg::item_flags_t flags,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,
  output logic                  out_tuser
);

  localparam int PHW = $clog2(2 * CODE_BITS + 1);

  logic [PHW-1:0]       phase_r, phase_nxt;
  logic [CODE_BITS-1:0] shift_r, shift_nxt;
  logic                 done_r, done_nxt;
  logic                 ov_r, ov_nxt;
  logic                 ok_r;
  logic [31:0]          code_r;
  logic                 emit, emit_ok;
  logic                 hdr_m, bit_m, one_m, zero_m;

  function automatic logic in_win(input logic [PW-1:0] pi, input logic [PW-1:0] pd,
                                  input logic dz, input irpd_pkg::win_t w);
    return (PW'(w.lo_x) < pi) && (dz || (pd <= PW'(w.hi_x)));
  endfunction

  assign hdr_m  = in_win(p_inc, p_dec, flags.dur_zero, win.hdr);
  assign bit_m  = in_win(p_inc, p_dec, flags.dur_zero, win.bmark);
  assign one_m  = in_win(p_inc, p_dec, flags.dur_zero, win.one);
  assign zero_m = in_win(p_inc, p_dec, flags.dur_zero, win.zero);

  assign pop = q_valid && (!ov_r || out_tready);

  always_comb begin
    logic fail;
    logic succ;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    done_nxt  = done_r;
    emit      = 1'b0;
    emit_ok   = 1'b0;
    fail      = 1'b0;
    succ      = 1'b0;
    if (pop) begin
      if (flags.first) begin
        // A leading gap restarts the capture; if it is also the last item,
        // the capture fails on the spot.
        phase_nxt = '0;
        shift_nxt = '0;
        done_nxt  = flags.last;
        emit      = flags.last;
      end else if (!done_r) begin
        if (phase_r == '0) begin
          fail = !hdr_m;
        end else if (phase_r[0]) begin
          if (one_m) begin
            shift_nxt = (shift_r << 1) | CODE_BITS'(1);
          end else if (zero_m) begin
            shift_nxt = shift_r << 1;
          end else begin
            fail = 1'b1;
          end
        end else begin
          if (!bit_m) begin
            fail = 1'b1;
          end else if (phase_r >= PHW'(2 * CODE_BITS)) begin
            succ = 1'b1;
          end
        end
        if (fail || succ) begin
          emit     = 1'b1;
          emit_ok  = succ;
          done_nxt = 1'b1;
        end else begin
          phase_nxt = phase_r + PHW'(1);
          if (flags.last) begin
            emit     = 1'b1;
            done_nxt = 1'b1;
          end
        end
      end
    end
    ov_nxt = ov_r;
    if (!ov_r || out_tready) begin
      ov_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      shift_r <= '0;
      done_r  <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      done_r  <= done_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ok_r   <= emit_ok;
      code_r <= emit_ok ? 32'(shift_r) : 32'd0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = code_r;
  assign out_tuser  = ok_r;

  a_fail_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ok_r) |-> (code_r == 32'd0))
    else $error("rejected capture carries a nonzero code");

  a_result_ends_capture: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> done_r)
    else $error("capture still open after its result");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && flags.first && !flags.last) |=> (phase_r == '0 && shift_r == '0 && !done_r))
    else $error("leading gap did not restart the capture");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |-> !emit)
    else $error("result produced while the output register is stalled");

endmodule

/* hdl/ir_pulse_distance_decoder.sv */
// A result appears on out_* after the input transaction that completes the capture, which
// passes through a queue entry and then the result register.
// Throughput: one input transaction per cycle while out_* is not stalled, set by the
// window compare and sequencer step in the back end; the two-entry queue absorbs stalls.
// Reset (rst_n low, synchronous): tolerance 25 percent, mark excess 100us,
// decoder idle until a leading gap, queue and result register empty.
module ir_pulse_distance_decoder #(
  parameter int TICK_US   = irpd_pkg::TICK_US_DEF,
  parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] duration_ticks
  input  logic        in_tuser,   // [0] first_entry
  input  logic        in_tlast,   // last_entry
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] code_value
  output logic        out_tuser   // [0] decoded_ok
);

  localparam int PW = 17 + $clog2(100 * TICK_US + 1);
  localparam int QW = 2 * PW + $bits(irpd_pkg::item_flags_t);

  irpd_pkg::win_set_t    win;
  logic [PW-1:0]         f_inc, f_dec, b_inc, b_dec;
  irpd_pkg::item_flags_t f_flags, b_flags;
  logic                  q_full, q_valid, pop;
  logic [QW-1:0]         q_rdata;

  irpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .win       (win)
  );

  irpd_front #(.TICK_US(TICK_US), .PW(PW)) u_front (
    .dur   (in_tdata),
    .first (in_tuser),
    .last  (in_tlast),
    .p_inc (f_inc),
    .p_dec (f_dec),
    .flags (f_flags)
  );

  irpd_queue #(.W(QW)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_tvalid && in_tready),
    .wdata  ({f_inc, f_dec, f_flags}),
    .full   (q_full),
    .pop    (pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  assign in_tready = !q_full;
  assign {b_inc, b_dec, b_flags} = q_rdata;

  irpd_back #(.TICK_US(TICK_US), .CODE_BITS(CODE_BITS), .PW(PW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .win        (win),
    .q_valid    (q_valid),
    .p_inc      (b_inc),
    .p_dec      (b_dec),
    .flags      (b_flags),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
